>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLKD(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Result types, opcode codes and header constants for the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_OVER  = 2'd3
  } kind_t;

  // Frame opcodes that the parser acts upon.
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Seven-bit length codes that select an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Number of bytes in each extended length field and in the mask key.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Reset value of the payload length limit (10 MiB).
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'(1024 * 1024 * 10);

  // One result as it sits in the output register.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and emits unmasked payload.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per clock cycle while in_stall is low
// and gives at most one result per byte. Header parsing, payload unmasking and
// the length check all happen in combinational logic between the frame state
// registers and the output register, so back-to-back bytes are taken at full
// rate. Results are registered in an output register backed by one skid entry,
// which takes a result while the output register waits; in_stall rises only
// when both hold a result that the receiver has not yet taken. After a close
// result or an oversize error the block discards every byte until reset.
// max_payload_len should be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [31:0]          cfg_data,
  // Received byte channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           rx_byte,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wsdf_pkg::kind_t           kind,
  output logic [7:0]                out_byte,
  output logic [3:0]                frame_opcode,
  output logic                      last
);

  import wsdf_pkg::*;

  // Largest length the payload counter can hold.
  localparam logic [63:0] COUNT_CAP = (COUNT_WIDTH >= 64) ? {64{1'b1}}
                                    : ((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  // Frame state.
  phase_t                   phase, phase_next;
  logic [3:0]               cur_opcode, cur_opcode_next;
  logic                     mask_present, mask_present_next;
  logic [63:0]              length_accum, length_accum_next;
  logic [3:0]               header_bytes_left, header_bytes_left_next;
  logic [31:0]              mask_key, mask_key_next;
  logic [1:0]               key_index, key_index_next;
  logic [COUNT_WIDTH-1:0]   payload_left, payload_left_next;
  logic [31:0]              max_payload_len;

  // Output register and skid entry.
  result_t                  out_res, skid_res, res;
  logic                     skid_valid;
  logic                     res_valid;

  logic                     in_accept;
  logic                     out_take;
  logic                     finish;
  logic                     oversize;
  logic [7:0]               key_byte;
  logic                     is_last;
  logic                     emits_bytes;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign kind         = out_res.kind;
  assign out_byte     = out_res.data;
  assign frame_opcode = out_res.opcode;
  assign last         = out_res.last;

  // Key byte for the current payload position; key byte 0 sits in bits 31:24.
  assign key_byte    = 8'(mask_key >> {~key_index, 3'b000});
  assign is_last     = (payload_left == COUNT_WIDTH'(1));
  assign emits_bytes = (cur_opcode == OP_TEXT) || (cur_opcode == OP_PING);
  assign oversize    = (length_accum_next > {32'd0, max_payload_len}) ||
                       (length_accum_next > COUNT_CAP);

  // Next frame state and the result for the byte on the input.
  always_comb begin
    phase_next             = phase;
    cur_opcode_next        = cur_opcode;
    mask_present_next      = mask_present;
    length_accum_next      = length_accum;
    header_bytes_left_next = header_bytes_left;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    payload_left_next      = payload_left;
    finish                 = 1'b0;
    res_valid              = 1'b0;
    res.kind               = KIND_BYTE;
    res.data               = 8'd0;
    res.opcode             = cur_opcode;
    res.last               = 1'b1;

    case (phase)
      PH_HDR0: begin
        cur_opcode_next = rx_byte[3:0];
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        mask_present_next = rx_byte[7];
        mask_key_next     = 32'd0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          length_accum_next      = 64'd0;
          header_bytes_left_next = EXT16_BYTES;
          phase_next             = PH_EXTLEN;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          length_accum_next      = 64'd0;
          header_bytes_left_next = EXT64_BYTES;
          phase_next             = PH_EXTLEN;
        end else begin
          length_accum_next = {57'd0, rx_byte[6:0]};
          if (rx_byte[7]) begin
            header_bytes_left_next = KEY_BYTES;
            phase_next             = PH_MASK;
          end else begin
            header_bytes_left_next = 4'd0;
            finish                 = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_accum_next      = {length_accum[55:0], rx_byte};
        header_bytes_left_next = header_bytes_left - 4'd1;
        if (header_bytes_left_next == 4'd0) begin
          if (mask_present) begin
            header_bytes_left_next = KEY_BYTES;
            phase_next             = PH_MASK;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_next          = {mask_key[23:0], rx_byte};
        header_bytes_left_next = header_bytes_left - 4'd1;
        if (header_bytes_left_next == 4'd0) begin
          finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_index_next    = key_index + 2'd1;
        payload_left_next = payload_left - COUNT_WIDTH'(1);
        if (is_last) begin
          phase_next = (cur_opcode == OP_CLOSE) ? PH_HALTED : PH_HDR0;
        end
        if (emits_bytes) begin
          res_valid = 1'b1;
          res.kind  = KIND_BYTE;
          res.data  = rx_byte ^ key_byte;
          res.last  = is_last;
        end else if (cur_opcode == OP_CLOSE && is_last) begin
          res_valid = 1'b1;
          res.kind  = KIND_CLOSE;
        end
      end
      default: begin
        phase_next = PH_HALTED;
      end
    endcase

    // End of header: length check, then payload or a close or empty result.
    if (finish) begin
      key_index_next = 2'd0;
      if (oversize) begin
        phase_next = PH_HALTED;
        res_valid  = 1'b1;
        res.kind   = KIND_OVER;
      end else begin
        payload_left_next = length_accum_next[COUNT_WIDTH-1:0];
        if (length_accum_next != 64'd0) begin
          phase_next = PH_PAYLOAD;
        end else if (cur_opcode == OP_CLOSE) begin
          phase_next = PH_HALTED;
          res_valid  = 1'b1;
          res.kind   = KIND_CLOSE;
        end else begin
          phase_next = PH_HDR0;
          if (emits_bytes) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end
        end
      end
    end
  end

  // State, configuration and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      cur_opcode        <= 4'd0;
      mask_present      <= 1'b0;
      length_accum      <= 64'd0;
      header_bytes_left <= 4'd0;
      mask_key          <= 32'd0;
      key_index         <= 2'd0;
      payload_left      <= '0;
      max_payload_len   <= MAX_PAYLOAD_RESET;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_payload_len <= cfg_data;
      end

      if (in_accept) begin
        phase             <= phase_next;
        cur_opcode        <= cur_opcode_next;
        mask_present      <= mask_present_next;
        length_accum      <= length_accum_next;
        header_bytes_left <= header_bytes_left_next;
        mask_key          <= mask_key_next;
        key_index         <= key_index_next;
        payload_left      <= payload_left_next;
      end

      // The skid entry drains first; a new result fills the output
      // register when it is free, else the skid entry.
      if (skid_valid) begin
        if (out_take) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (in_accept && res_valid) begin
        if (!out_valid || out_take) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The skid entry only fills behind a waiting output register.
  `ASSERT_NEVER(a_skid_without_out, clk, rst, skid_valid && !out_valid, "skid entry full while output register is empty")
  // Once halted the parser stays halted until reset.
  `ASSERT_CLKD(a_halt_sticks, clk, rst, (phase == PH_HALTED) |=> (phase == PH_HALTED), "parser left the halted phase")
  // A payload phase always has bytes left to consume.
  `ASSERT_NEVER(a_payload_count, clk, rst, (phase == PH_PAYLOAD) && (payload_left == '0), "payload phase with no bytes left")
  // Header field phases always have bytes left to read.
  `ASSERT_NEVER(a_header_count, clk, rst, ((phase == PH_EXTLEN) || (phase == PH_MASK)) && (header_bytes_left == 4'd0), "header phase with no bytes left")

endmodule

`default_nettype wire
